FILE: src/rscf_pkg.sv
// ----------------------------------------------------------------------------
// rscf_pkg
// Shared types and codes for the redundant state command filter.
// ----------------------------------------------------------------------------
package rscf_pkg;

  // Command opcodes. Codes above OP_TEXTURE are not cached and always pass.
  localparam logic [3:0] OP_FRAME_START = 4'd0;
  localparam logic [3:0] OP_DEPTH       = 4'd1;
  localparam logic [3:0] OP_BLEND       = 4'd2;
  localparam logic [3:0] OP_BLEND_FUNC  = 4'd3;
  localparam logic [3:0] OP_BLEND_EQ    = 4'd4;
  localparam logic [3:0] OP_CULL        = 4'd5;
  localparam logic [3:0] OP_VIEWPORT    = 4'd6;
  localparam logic [3:0] OP_SCISSOR     = 4'd7;
  localparam logic [3:0] OP_FRAMEBUFFER = 4'd8;
  localparam logic [3:0] OP_TEXTURE     = 4'd9;

  // Configuration register indexes.
  localparam logic CFG_FACTOR   = 1'b0;
  localparam logic CFG_EQUATION = 1'b1;

  // One command beat as it travels down the pipeline.
  typedef struct packed {
    logic [3:0]  opcode;
    logic        enable_bit;
    logic [3:0]  factor_or_equation;
    logic [3:0]  dest_factor;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_w;
    logic [15:0] rect_h;
    logic [31:0] target_id;
    logic [31:0] image_id;
    logic [31:0] program_id;
    logic [5:0]  unit_slot;
  } cmd_t;

  // One entry of the per-slot texture/shader table.
  typedef struct packed {
    logic [31:0] image_id;
    logic [31:0] program_id;
  } slot_entry_t;

  // Slot table update from the decision stage.
  typedef struct packed {
    logic        en;
    logic        clear;
    logic [5:0]  slot;
    slot_entry_t data;
  } slot_wr_t;

endpackage

FILE: src/rscf_ram.sv
// ----------------------------------------------------------------------------
// rscf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rscf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/rscf_slot_cache.sv
// ----------------------------------------------------------------------------
// rscf_slot_cache
// Per-slot texture/shader table: RAM, per-entry valid bits and forwarding of
// a write that lands on the same edge as the read of the same entry.
// ----------------------------------------------------------------------------
module rscf_slot_cache
  import rscf_pkg::*;
#(
  parameter int SLOT_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [5:0]  rd_slot,
  input  slot_wr_t    wr,
  output slot_entry_t entry
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [AW-1:0]         lu_addr;
  logic [SLOT_COUNT-1:0] slot_valid;
  logic                  fwd_hit;
  slot_entry_t           fwd_data;
  logic [63:0]           ram_q;

  assign rd_addr = rd_slot[AW-1:0];
  assign wr_addr = wr.slot[AW-1:0];

  rscf_ram #(
    .WIDTH (64),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr_addr),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  // Valid bits: set on a write, cleared at once by reset or frame start.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr.clear) begin
      slot_valid <= '0;
    end else if (wr.en) begin
      slot_valid[wr_addr] <= 1'b1;
    end
  end

  // Capture a write that races the read of the same entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (rd_en) begin
      fwd_hit <= wr.en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data <= wr.data;
      lu_addr  <= rd_addr;
    end
  end

  // An entry not written since the last clear reads as zero handles.
  always_comb begin
    if (!slot_valid[lu_addr]) begin
      entry = '0;
    end else if (fwd_hit) begin
      entry = fwd_data;
    end else begin
      entry = slot_entry_t'(ram_q);
    end
  end

endmodule

FILE: src/rscf_state.sv
// ----------------------------------------------------------------------------
// rscf_state
// Cached render state and the pass/drop decision for one command beat.
// ----------------------------------------------------------------------------
module rscf_state
  import rscf_pkg::*;
#(
  parameter int SLOT_COUNT = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        apply,
  input  cmd_t        cmd,
  input  slot_entry_t entry,
  input  logic [3:0]  default_factor_code,
  input  logic [2:0]  default_equation_code,
  output logic        dispatch,
  output slot_wr_t    wr
);

  logic        depth_on;
  logic        blend_on;
  logic        cull_on;
  logic [3:0]  src_factor;
  logic [3:0]  dst_factor;
  logic [2:0]  equation_code;
  logic [63:0] view_rect;
  logic [63:0] clip_rect;
  logic [31:0] bound_target;
  logic        target_valid;
  logic        seen_any;
  logic        slots_seen;

  logic [63:0] rect;
  logic        in_range;
  logic        drop;
  logic        store;

  assign rect     = {cmd.rect_h, cmd.rect_w, cmd.rect_y, cmd.rect_x};
  assign in_range = {1'b0, cmd.unit_slot} < 7'(SLOT_COUNT);

  // Redundancy check against the cached value of the command's kind.
  always_comb begin
    drop = 1'b0;
    unique case (cmd.opcode)
      OP_FRAME_START: drop = 1'b1;
      OP_DEPTH:       drop = seen_any && (depth_on == cmd.enable_bit);
      OP_BLEND:       drop = seen_any && (blend_on == cmd.enable_bit);
      OP_BLEND_FUNC:  drop = seen_any && (src_factor == cmd.factor_or_equation)
                             && (dst_factor == cmd.dest_factor);
      OP_BLEND_EQ:    drop = seen_any && (equation_code == cmd.factor_or_equation[2:0]);
      OP_CULL:        drop = seen_any && (cull_on == cmd.enable_bit);
      OP_VIEWPORT:    drop = seen_any && (view_rect == rect);
      OP_SCISSOR:     drop = seen_any && (clip_rect == rect);
      OP_FRAMEBUFFER: drop = seen_any && target_valid && (bound_target == cmd.target_id);
      OP_TEXTURE:     drop = in_range && slots_seen && (entry.image_id == cmd.image_id)
                             && (entry.program_id == cmd.program_id);
      default:        drop = 1'b0;
    endcase
  end

  assign dispatch = !drop;
  assign store    = apply && !drop;

  // Slot table write and frame-start clear.
  always_comb begin
    wr.en              = store && (cmd.opcode == OP_TEXTURE) && in_range;
    wr.clear           = apply && (cmd.opcode == OP_FRAME_START);
    wr.slot            = cmd.unit_slot;
    wr.data.image_id   = cmd.image_id;
    wr.data.program_id = cmd.program_id;
  end

  // Flags and handle-valid state.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any     <= 1'b0;
      slots_seen   <= 1'b0;
      target_valid <= 1'b0;
    end else if (wr.clear) begin
      seen_any     <= 1'b0;
      slots_seen   <= 1'b0;
      target_valid <= 1'b0;
    end else if (store && (cmd.opcode <= OP_TEXTURE)) begin
      seen_any <= 1'b1;
      if (cmd.opcode == OP_FRAMEBUFFER) begin
        target_valid <= 1'b1;
      end
      if (wr.en) begin
        slots_seen <= 1'b1;
      end
    end
  end

  // Cached values: restored at reset and frame start, stored on a pass.
  always_ff @(posedge clk) begin
    if (rst || wr.clear) begin
      depth_on      <= 1'b0;
      blend_on      <= 1'b0;
      cull_on       <= 1'b0;
      src_factor    <= rst ? 4'd1 : default_factor_code;
      dst_factor    <= rst ? 4'd1 : default_factor_code;
      equation_code <= rst ? 3'd0 : default_equation_code;
      view_rect     <= '1;
      clip_rect     <= '1;
      bound_target  <= '0;
    end else if (store) begin
      unique case (cmd.opcode)
        OP_DEPTH:       depth_on <= cmd.enable_bit;
        OP_BLEND:       blend_on <= cmd.enable_bit;
        OP_BLEND_FUNC: begin
          src_factor <= cmd.factor_or_equation;
          dst_factor <= cmd.dest_factor;
        end
        OP_BLEND_EQ:    equation_code <= cmd.factor_or_equation[2:0];
        OP_CULL:        cull_on <= cmd.enable_bit;
        OP_VIEWPORT:    view_rect <= rect;
        OP_SCISSOR:     clip_rect <= rect;
        OP_FRAMEBUFFER: bound_target <= cmd.target_id;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: src/redundant_state_command_filter.sv
// Flow: lookup stage register (with the slot RAM read), decision stage, then
// output register. Throughput: one command per cycle while res_stall is low;
// the slot RAM is read as a command enters and written from the decision
// stage, with same-entry writes forwarded.
// Reset: flags, cached state, configuration and the slot valid bits clear at
// once; no clearing pass runs over the slot RAM.
// ----------------------------------------------------------------------------
// redundant_state_command_filter
// Drops frame starts and render state commands that repeat the cached value;
// passes the rest.
module redundant_state_command_filter
  import rscf_pkg::*;
#(
  parameter int SLOT_COUNT = 32
) (
  input  logic               clk,
  input  logic               rst,
  // Configuration write port.
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [3:0]         cfg_data,
  // Command channel.
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  logic [3:0]         opcode,
  input  logic               enable_bit,
  input  logic [3:0]         factor_or_equation,
  input  logic [3:0]         dest_factor,
  input  logic signed [15:0] rect_x,
  input  logic signed [15:0] rect_y,
  input  logic signed [15:0] rect_w,
  input  logic signed [15:0] rect_h,
  input  logic [31:0]        target_id,
  input  logic [31:0]        image_id,
  input  logic [31:0]        program_id,
  input  logic [5:0]         unit_slot,
  // Result channel.
  output logic               res_valid,
  input  logic               res_stall,
  output logic               dispatch
);

  logic [3:0]  factor_reg;
  logic [2:0]  equation_reg;
  logic        accept;
  logic        advance;
  logic        s1_valid;
  cmd_t        s1_cmd;
  cmd_t        in_cmd;
  slot_entry_t entry;
  slot_wr_t    slot_wr;
  logic        decision;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      factor_reg   <= 4'd1;
      equation_reg <= 3'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FACTOR:   factor_reg   <= cfg_data;
        CFG_EQUATION: equation_reg <= cfg_data[2:0];
      endcase
    end
  end

  // Handshake: the decision stage moves on whenever the output register frees.
  assign advance   = s1_valid && (!res_valid || !res_stall);
  assign cmd_stall = s1_valid && !advance;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    in_cmd.opcode             = opcode;
    in_cmd.enable_bit         = enable_bit;
    in_cmd.factor_or_equation = factor_or_equation;
    in_cmd.dest_factor        = dest_factor;
    in_cmd.rect_x             = rect_x;
    in_cmd.rect_y             = rect_y;
    in_cmd.rect_w             = rect_w;
    in_cmd.rect_h             = rect_h;
    in_cmd.target_id          = target_id;
    in_cmd.image_id           = image_id;
    in_cmd.program_id         = program_id;
    in_cmd.unit_slot          = unit_slot;
  end

  // Lookup stage register; the slot RAM read runs alongside it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= in_cmd;
    end
  end

  rscf_slot_cache #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_slot_cache (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_slot (unit_slot),
    .wr      (slot_wr),
    .entry   (entry)
  );

  rscf_state #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_state (
    .clk                   (clk),
    .rst                   (rst),
    .apply                 (advance),
    .cmd                   (s1_cmd),
    .entry                 (entry),
    .default_factor_code   (factor_reg),
    .default_equation_code (equation_reg),
    .dispatch              (decision),
    .wr                    (slot_wr)
  );

  // Output register holds the result beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dispatch <= decision;
    end
  end

endmodule
